[rtl/mnep_pkg.sv]
// mnep_pkg: shared types and constants for the midi note event parser
// no dependencies; imported by the channel interfaces and the top level

package mnep_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned TIME_W    = 48;
    localparam int unsigned DATA_W    = 7;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned CHANNEL_W = 5;

    localparam logic [BYTE_W-1:0] REALTIME_FIRST = 8'hF8;
    localparam logic [3:0]        MSG_NOTE_OFF   = 4'h8;
    localparam logic [3:0]        MSG_NOTE_ON    = 4'h9;
    localparam logic [3:0]        MSG_CONTROL    = 4'hB;
    localparam logic [3:0]        MSG_PROGRAM    = 4'hC;
    localparam logic [3:0]        MSG_PRESSURE   = 4'hD;
    localparam logic [3:0]        MSG_SYSTEM     = 4'hF;

    localparam logic [DATA_W-1:0] SUSTAIN_CONTROLLER = 7'd64;
    localparam logic [DATA_W-1:0] SUSTAIN_THRESHOLD  = 7'd64;

    typedef enum logic [KIND_W-1:0] {
        KIND_NOTE_OFF    = 2'd0,
        KIND_NOTE_ON     = 2'd1,
        KIND_SUSTAIN_ON  = 2'd2,
        KIND_SUSTAIN_OFF = 2'd3
    } t_event_kind;

endpackage

[rtl/mnep_if.sv]
// mnep_midi_if and mnep_event_if: valid/ready channels for midi bytes and note events
// depends on mnep_pkg

interface mnep_midi_if;
    import mnep_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] midi_byte;
    logic [TIME_W-1:0] time_stamp;

    modport source (output valid, output midi_byte, output time_stamp, input ready);
    modport sink   (input valid, input midi_byte, input time_stamp, output ready);
endinterface

interface mnep_event_if;
    import mnep_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    event_kind;
    logic [DATA_W-1:0]    note_number;
    logic [DATA_W-1:0]    level;
    logic [TIME_W-1:0]    event_time;
    logic [CHANNEL_W-1:0] channel_number;

    modport source (
        output valid, output event_kind, output note_number, output level,
        output event_time, output channel_number, input ready
    );
    modport sink (
        input valid, input event_kind, input note_number, input level,
        input event_time, input channel_number, output ready
    );
endinterface

[rtl/midi_note_event_parser_top.sv]
// midi_note_event_parser_top: running-status midi parser emitting note and sustain events
// depends on mnep_pkg and the mnep_midi_if / mnep_event_if channels

// One midi byte with its timestamp enters per transaction, and a new byte can be taken in
// every cycle unless an unread event stalls the output. From the input register a byte
// updates the running status, the data byte count and the first data byte, and an event
// it completes is registered in the output register. Real-time bytes are dropped, system
// exclusive and system-common bytes clear the running status, and only note on, note off
// and sustain pedal (controller 64) messages produce an event; note on with velocity 0 is
// reported as note off. Level is the raw 7-bit velocity or pedal value, 0 for note off.

module midi_note_event_parser_top (
    input logic          i_clk,
    input logic          i_rst_n,
    mnep_midi_if.sink    i_midi,
    mnep_event_if.source o_event
);
    import mnep_pkg::*;

    logic                 r_in_valid;
    logic [BYTE_W-1:0]    r_in_byte;
    logic [TIME_W-1:0]    r_in_time;

    logic [BYTE_W-1:0]    r_status, n_status;
    logic [1:0]           r_count, n_count;
    logic [DATA_W-1:0]    r_first, n_first;

    logic                 r_out_valid;
    t_event_kind          r_out_kind, n_out_kind;
    logic [DATA_W-1:0]    r_out_note, n_out_note;
    logic [DATA_W-1:0]    r_out_level, n_out_level;
    logic [TIME_W-1:0]    r_out_time;
    logic [CHANNEL_W-1:0] r_out_channel;

    logic                 fire;
    logic                 event_hit;
    logic [3:0]           msg;
    logic [1:0]           needed;
    logic [1:0]           count_inc;
    logic [DATA_W-1:0]    second;
    logic                 note_off;

    assign fire          = r_in_valid && (!r_out_valid || o_event.ready);
    assign i_midi.ready  = !r_in_valid || fire;
    assign msg           = r_status[7:4];
    assign second        = r_in_byte[DATA_W-1:0];
    assign count_inc     = r_count + 2'd1;
    assign needed        = (msg == MSG_PROGRAM || msg == MSG_PRESSURE) ? 2'd1 : 2'd2;
    assign note_off      = (msg == MSG_NOTE_OFF) || (second == '0);

    always_comb begin
        n_status    = r_status;
        n_count     = r_count;
        n_first     = r_first;
        event_hit   = 1'b0;
        n_out_kind  = KIND_NOTE_OFF;
        n_out_note  = '0;
        n_out_level = '0;
        if (r_in_byte >= REALTIME_FIRST) begin
            n_status = r_status;
        end else if (r_in_byte[BYTE_W-1]) begin
            n_count  = '0;
            n_status = (r_in_byte[7:4] == MSG_SYSTEM) ? '0 : r_in_byte;
        end else if (r_status != '0) begin
            if (r_count == 2'd0) begin
                n_first = second;
            end
            if (count_inc < needed) begin
                n_count = count_inc;
            end else begin
                n_count = '0;
                if (msg == MSG_NOTE_OFF || msg == MSG_NOTE_ON) begin
                    event_hit   = 1'b1;
                    n_out_kind  = note_off ? KIND_NOTE_OFF : KIND_NOTE_ON;
                    n_out_note  = n_first;
                    n_out_level = note_off ? '0 : second;
                end else if (msg == MSG_CONTROL && n_first == SUSTAIN_CONTROLLER) begin
                    event_hit   = 1'b1;
                    n_out_kind  = (second >= SUSTAIN_THRESHOLD) ? KIND_SUSTAIN_ON
                                                                : KIND_SUSTAIN_OFF;
                    n_out_level = second;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_status    <= '0;
            r_count     <= '0;
            r_first     <= '0;
        end else begin
            if (i_midi.ready) begin
                r_in_valid <= i_midi.valid;
            end
            if (fire) begin
                r_status <= n_status;
                r_count  <= n_count;
                r_first  <= n_first;
            end
            if (fire) begin
                r_out_valid <= event_hit;
            end else if (o_event.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_midi.valid && i_midi.ready) begin
            r_in_byte <= i_midi.midi_byte;
            r_in_time <= i_midi.time_stamp;
        end
        if (fire && event_hit) begin
            r_out_kind    <= n_out_kind;
            r_out_note    <= n_out_note;
            r_out_level   <= n_out_level;
            r_out_time    <= r_in_time;
            r_out_channel <= {1'b0, r_status[3:0]} + CHANNEL_W'(1);
        end
    end

    assign o_event.valid          = r_out_valid;
    assign o_event.event_kind     = r_out_kind;
    assign o_event.note_number    = r_out_note;
    assign o_event.level          = r_out_level;
    assign o_event.event_time     = r_out_time;
    assign o_event.channel_number = r_out_channel;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd1)
        else $error("data byte count beyond one");

    a_no_status_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status == '0) |-> (r_count == 2'd0))
        else $error("data count without running status");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status == '0) || (r_status[7] && r_status[7:4] != MSG_SYSTEM))
        else $error("illegal running status");

    a_event_from_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && event_hit) |-> !r_in_byte[BYTE_W-1])
        else $error("event raised by a status byte");

    a_sustain_note_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == KIND_SUSTAIN_ON || r_out_kind == KIND_SUSTAIN_OFF))
        |-> (r_out_note == '0))
        else $error("sustain event carries a note number");

    a_stall_holds_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_event.ready) |=> (r_out_valid && $stable(r_out_time)))
        else $error("stalled event lost");

endmodule
